/* rtl/core/qnl_pkg.sv */
package qnl_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // blend of 1.0 in fixed point
  localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic {
    OP_VEC  = 1'b0,
    OP_QUAT = 1'b1
  } op_t;

  typedef struct packed {
    op_t   operation;
    word_t from_c0;
    word_t from_c1;
    word_t from_c2;
    word_t from_c3;
    word_t to_c0;
    word_t to_c1;
    word_t to_c2;
    word_t to_c3;
    word_t blend;
  } in_item_t;

  typedef struct packed {
    word_t out_c0;
    word_t out_c1;
    word_t out_c2;
    word_t out_c3;
    logic  zero_length;
  } out_item_t;

endpackage

/* rtl/core/qnl_if.sv */
interface qnl_in_if;
  logic               valid;
  logic               ready;
  qnl_pkg::in_item_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface qnl_out_if;
  logic               valid;
  logic               ready;
  qnl_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/quaternion_nlerp_interpolator.sv */
// Channel | Dir | Payload                                   | Handshake
// in_ch   | in  | operation, from_c0..3, to_c0..3, blend    | valid/ready
// out_ch  | out | out_c0..3, zero_length                    | valid/ready
//
// One item per cycle sustained while the output channel takes results.
// The pipeline holds the 32-step square root and the 17-step divide, one step per stage.
// Synchronous active-low reset clears the stage valid bits and the output valid.
// The pipeline advances whenever its last stage is empty or the output register can
// take it, so a stalled result holds the whole pipe; nothing is dropped or repeated.
module quaternion_nlerp_interpolator (
  input  logic       clk,
  input  logic       rst_n,
  qnl_in_if.sink     in_ch,
  qnl_out_if.source  out_ch
);

  localparam int FB    = qnl_pkg::FRAC_BITS;
  localparam int WB    = qnl_pkg::WORD_BITS;
  localparam int N_FE  = 9;            // front-end stages: load through square sum
  localparam int N_SQ  = WB;           // one root bit per stage
  localparam int N_DV  = FB + 1;       // quotient is at most 1.0, so FB+1 bits
  localparam int NSTG  = N_FE + (N_SQ + 1) + (N_DV + 1);
  localparam int LEN_W = WB + 1;
  localparam int NUM_W = WB + FB;
  localparam int REM_W = WB + 2;

  typedef logic [3:0][WB-1:0] vec4_t;
  typedef logic [3:0][WB:0]   rvec_t;   // blended components, one spare bit

  typedef struct packed {
    qnl_pkg::op_t op;
    vec4_t        from;
    vec4_t        to;
    logic [FB:0]  amt;
  } ld_t;

  typedef struct packed {
    qnl_pkg::op_t   op;
    vec4_t          from;
    vec4_t          to;
    logic [FB:0]    amt;
    logic [3:0][2*WB-1:0] p;
  } dp_t;

  typedef struct packed {
    qnl_pkg::op_t op;
    vec4_t        from;
    vec4_t        to;
    logic [FB:0]  amt;
    logic [2*WB:0] d01;
    logic [2*WB:0] d23;
  } ds_t;

  typedef struct packed {
    qnl_pkg::op_t op;
    vec4_t        from;
    vec4_t        to;
    logic [FB:0]  amt;
    logic         neg;
  } ng_t;

  typedef struct packed {
    qnl_pkg::op_t      op;
    vec4_t             from;
    logic [FB:0]       amt;
    logic [3:0][WB+1:0] diff;
  } df_t;

  typedef struct packed {
    qnl_pkg::op_t          op;
    vec4_t                 from;
    logic [3:0][WB+FB+3:0] sc;
  } sc_t;

  typedef struct packed {
    qnl_pkg::op_t op;
    rvec_t        r;
  } rr_t;

  typedef struct packed {
    qnl_pkg::op_t         op;
    rvec_t                r;
    logic [3:0][2*WB-1:0] sq;
  } sq_t;

  typedef struct packed {
    qnl_pkg::op_t op;
    rvec_t        r;
    logic [2*WB:0] s01;
    logic [2*WB:0] s23;
  } ss_t;

  typedef struct packed {
    qnl_pkg::op_t    op;
    rvec_t           r;
    logic            big;
    logic            zero;
    logic [REM_W-1:0] rem;
    logic [WB-1:0]   root;
    logic [2*WB-1:0] s;
  } rt_t;

  typedef struct packed {
    qnl_pkg::op_t           op;
    rvec_t                  r;
    logic                   zero;
    logic [LEN_W-1:0]       len;
    logic [3:0][NUM_W-1:0]  rem;
    logic [3:0][FB:0]       q;
  } dv_t;

  logic            en;
  logic            in_fire;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  ld_t a_r, a_nxt;
  dp_t b_r, b_nxt;
  ds_t c_r, c_nxt;
  ng_t d_r, d_nxt;
  df_t e_r, e_nxt;
  sc_t f_r, f_nxt;
  rr_t g_r, g_nxt;
  sq_t h_r, h_nxt;
  ss_t i_r, i_nxt;
  rt_t rt_r [N_SQ+1];
  rt_t rt_nxt [N_SQ+1];
  dv_t dv_r [N_DV+1];
  dv_t dv_nxt [N_DV+1];

  qnl_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r;
  logic               out_load;

  // --- flow control -------------------------------------------------------
  // Whole pipe moves as one; a stalled result only blocks once it reaches
  // the last stage. No item is taken while reset is held.
  assign out_load    = !out_valid_r || out_ch.ready;
  assign en          = !vld_r[NSTG-1] || out_load;
  assign in_ch.ready = en && rst_n;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign vld_nxt     = {vld_r[NSTG-2:0], in_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // --- load: clamp blend to [0, 1.0] --------------------------------------
  always_comb begin
    a_nxt.op   = in_ch.data.operation;
    a_nxt.from = {in_ch.data.from_c3, in_ch.data.from_c2,
                  in_ch.data.from_c1, in_ch.data.from_c0};
    a_nxt.to   = {in_ch.data.to_c3, in_ch.data.to_c2,
                  in_ch.data.to_c1, in_ch.data.to_c0};
    if (in_ch.data.blend < 0) begin
      a_nxt.amt = '0;
    end else if (in_ch.data.blend > $signed(WB'(qnl_pkg::ONE_FX))) begin
      a_nxt.amt = qnl_pkg::ONE_FX;
    end else begin
      a_nxt.amt = in_ch.data.blend[FB:0];
    end
  end

  // --- dot product: four products, pair sums, sign ------------------------
  always_comb begin
    b_nxt.op   = a_r.op;
    b_nxt.from = a_r.from;
    b_nxt.to   = a_r.to;
    b_nxt.amt  = a_r.amt;
    for (int i = 0; i < 4; i++) begin
      b_nxt.p[i] = $signed(a_r.from[i]) * $signed(a_r.to[i]);
    end
  end

  always_comb begin
    c_nxt.op   = b_r.op;
    c_nxt.from = b_r.from;
    c_nxt.to   = b_r.to;
    c_nxt.amt  = b_r.amt;
    c_nxt.d01  = (2*WB+1)'($signed(b_r.p[0])) + (2*WB+1)'($signed(b_r.p[1]));
    c_nxt.d23  = (2*WB+1)'($signed(b_r.p[2])) + (2*WB+1)'($signed(b_r.p[3]));
  end

  always_comb begin
    logic signed [2*WB+1:0] dot;
    dot        = (2*WB+2)'($signed(c_r.d01)) + (2*WB+2)'($signed(c_r.d23));
    d_nxt.op   = c_r.op;
    d_nxt.from = c_r.from;
    d_nxt.to   = c_r.to;
    d_nxt.amt  = c_r.amt;
    d_nxt.neg  = dot[2*WB+1];
  end

  // --- lerp: difference, scale, truncate toward zero, add -----------------
  always_comb begin
    logic signed [WB:0] e;
    e_nxt.op   = d_r.op;
    e_nxt.from = d_r.from;
    e_nxt.amt  = d_r.amt;
    for (int i = 0; i < 4; i++) begin
      e = (WB+1)'($signed(d_r.to[i]));
      if (d_r.op == qnl_pkg::OP_QUAT && d_r.neg) begin
        e = -e;
      end
      e_nxt.diff[i] = (WB+2)'(e) - (WB+2)'($signed(d_r.from[i]));
    end
  end

  always_comb begin
    f_nxt.op   = e_r.op;
    f_nxt.from = e_r.from;
    for (int i = 0; i < 4; i++) begin
      f_nxt.sc[i] = (WB+FB+4)'($signed(e_r.diff[i]) * $signed({1'b0, e_r.amt}));
    end
  end

  always_comb begin
    logic signed [WB+FB+3:0] t;
    logic signed [WB+3:0]    qq;
    g_nxt.op = f_r.op;
    for (int i = 0; i < 4; i++) begin
      t = $signed(f_r.sc[i]);
      if (t < 0) begin
        t = t + (WB+FB+4)'((1 << FB) - 1);
      end
      qq = (WB+4)'(t >>> FB);
      g_nxt.r[i] = (WB+1)'(qq + (WB+4)'($signed(f_r.from[i])));
    end
  end

  // --- squared length -----------------------------------------------------
  always_comb begin
    logic signed [WB:0] rv;
    logic [WB-1:0]      m;
    h_nxt.op = g_r.op;
    h_nxt.r  = g_r.r;
    for (int i = 0; i < 4; i++) begin
      rv = $signed(g_r.r[i]);
      m  = (rv < 0) ? WB'(-rv) : WB'(rv);
      h_nxt.sq[i] = m * m;
    end
  end

  always_comb begin
    i_nxt.op  = h_r.op;
    i_nxt.r   = h_r.r;
    i_nxt.s01 = (2*WB+1)'(h_r.sq[0]) + (2*WB+1)'(h_r.sq[1]);
    i_nxt.s23 = (2*WB+1)'(h_r.sq[2]) + (2*WB+1)'(h_r.sq[3]);
  end

  always_comb begin
    logic [2*WB+1:0] tot;
    tot              = (2*WB+2)'(i_r.s01) + (2*WB+2)'(i_r.s23);
    rt_nxt[0].op     = i_r.op;
    rt_nxt[0].r      = i_r.r;
    rt_nxt[0].big    = |tot[2*WB+1:2*WB];
    rt_nxt[0].zero   = (tot == '0);
    rt_nxt[0].rem    = '0;
    rt_nxt[0].root   = '0;
    rt_nxt[0].s      = tot[2*WB-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      c_r       <= c_nxt;
      d_r       <= d_nxt;
      e_r       <= e_nxt;
      f_r       <= f_nxt;
      g_r       <= g_nxt;
      h_r       <= h_nxt;
      i_r       <= i_nxt;
      rt_r[0]   <= rt_nxt[0];
    end
  end

  // --- integer square root, two radicand bits per stage --------------------
  for (genvar k = 1; k <= N_SQ; k++) begin : g_sqrt
    always_comb begin
      logic [REM_W+1:0] rem2;
      logic [REM_W+1:0] trial;
      rt_nxt[k]    = rt_r[k-1];
      rem2         = {rt_r[k-1].rem, rt_r[k-1].s[2*WB-1 -: 2]};
      trial        = (REM_W+2)'({rt_r[k-1].root, 2'b01});
      rt_nxt[k].s  = {rt_r[k-1].s[2*WB-3:0], 2'b00};
      if (rem2 >= trial) begin
        rt_nxt[k].rem  = REM_W'(rem2 - trial);
        rt_nxt[k].root = {rt_r[k-1].root[WB-2:0], 1'b1};
      end else begin
        rt_nxt[k].rem  = REM_W'(rem2);
        rt_nxt[k].root = {rt_r[k-1].root[WB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[k] <= rt_nxt[k];
      end
    end
  end

  // --- divider setup: magnitude scaled by 1.0, length (overflow -> 2^WB) ---
  always_comb begin
    logic signed [WB:0] rv;
    logic [WB-1:0]      m;
    dv_nxt[0].op   = rt_r[N_SQ].op;
    dv_nxt[0].r    = rt_r[N_SQ].r;
    dv_nxt[0].zero = rt_r[N_SQ].zero;
    dv_nxt[0].len  = rt_r[N_SQ].big ? (LEN_W'(1) << WB) : LEN_W'(rt_r[N_SQ].root);
    dv_nxt[0].q    = '0;
    for (int i = 0; i < 4; i++) begin
      rv = $signed(rt_r[N_SQ].r[i]);
      m  = (rv < 0) ? WB'(-rv) : WB'(rv);
      dv_nxt[0].rem[i] = {m, FB'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_nxt[0];
    end
  end

  // --- restoring divide, one quotient bit per stage, four lanes -------------
  for (genvar j = 1; j <= N_DV; j++) begin : g_div
    localparam int K = N_DV - j;
    always_comb begin
      logic [NUM_W:0] dvs;
      dv_nxt[j] = dv_r[j-1];
      dvs       = (NUM_W+1)'(dv_r[j-1].len) << K;
      for (int i = 0; i < 4; i++) begin
        if ((NUM_W+1)'(dv_r[j-1].rem[i]) >= dvs) begin
          dv_nxt[j].rem[i] = NUM_W'((NUM_W+1)'(dv_r[j-1].rem[i]) - dvs);
          dv_nxt[j].q[i]   = dv_r[j-1].q[i] | ((FB+1)'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // --- result select and output register -----------------------------------
  function automatic qnl_pkg::word_t sat_word(input logic signed [WB:0] v);
    logic signed [WB:0] hi;
    logic signed [WB:0] lo;
    hi = (WB+1)'({1'b0, {(WB-1){1'b1}}});
    lo = -hi - (WB+1)'(1);
    if (v > hi) begin
      return qnl_pkg::word_t'(hi);
    end else if (v < lo) begin
      return qnl_pkg::word_t'(lo);
    end
    return qnl_pkg::word_t'(v);
  endfunction

  always_comb begin
    qnl_pkg::word_t c [4];
    logic signed [WB-1:0] qv;
    for (int i = 0; i < 4; i++) begin
      qv = $signed(WB'(dv_r[N_DV].q[i]));
      if (dv_r[N_DV].op == qnl_pkg::OP_VEC) begin
        c[i] = (i == 3) ? '0 : sat_word($signed(dv_r[N_DV].r[i]));
      end else if (dv_r[N_DV].zero) begin
        c[i] = '0;
      end else begin
        c[i] = dv_r[N_DV].r[i][WB] ? -qv : qv;
      end
    end
    out_nxt.out_c0      = c[0];
    out_nxt.out_c1      = c[1];
    out_nxt.out_c2      = c[2];
    out_nxt.out_c3      = c[3];
    out_nxt.zero_length = (dv_r[N_DV].op == qnl_pkg::OP_QUAT) && dv_r[N_DV].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // --- assertions -----------------------------------------------------------
  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) |-> (vld_r[0] == $past(in_fire)))
    else $error("first stage valid does not follow accepted item");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-1] && dv_r[N_DV].op == qnl_pkg::OP_QUAT && !dv_r[N_DV].zero)
      |-> (dv_r[N_DV].q[0] <= (FB+1)'(qnl_pkg::ONE_FX) &&
           dv_r[N_DV].q[3] <= (FB+1)'(qnl_pkg::ONE_FX)))
    else $error("normalized component above 1.0");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.zero_length) |->
      (out_r.out_c0 == '0 && out_r.out_c1 == '0 &&
       out_r.out_c2 == '0 && out_r.out_c3 == '0))
    else $error("zero-length result with nonzero component");

endmodule

/* tb/quaternion_nlerp_interpolator_test.sv */
module quaternion_nlerp_interpolator_test;

  // run limits, in clock cycles
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RAND_ITEMS = 1400;

  // Expected-result store plus a bit-true blend predictor.
  class blend_scoreboard;
    qnl_pkg::out_item_t pending[$];
    int mismatches;

    function automatic qnl_pkg::word_t sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return qnl_pkg::word_t'(v);
    endfunction

    // from + trunc((to - from) * amt / 2^16); trunc toward zero
    function automatic longint lerp(longint a, longint b, longint amt);
      return a + ((b - a) * amt) / 65536;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
      logic [127:0] c;
      longint unsigned acc;
      acc = 0;
      for (int b = 31; b >= 0; b--) begin
        c = 128'(acc | (64'd1 << b));
        if (c * c <= 128'(s)) acc = acc | (64'd1 << b);
      end
      return acc;
    endfunction

    function automatic qnl_pkg::out_item_t blend_result(qnl_pkg::in_item_t it);
      longint amt, fa[4], ta[4], r[4], m;
      logic signed [127:0] dot;
      logic [65:0] ssq;
      longint unsigned len;
      qnl_pkg::out_item_t res;
      amt = longint'(it.blend);
      if (amt < 0) amt = 0;
      if (amt > 65536) amt = 65536;
      fa = '{longint'(it.from_c0), longint'(it.from_c1), longint'(it.from_c2),
             longint'(it.from_c3)};
      ta = '{longint'(it.to_c0), longint'(it.to_c1), longint'(it.to_c2), longint'(it.to_c3)};
      res = '0;
      if (it.operation == qnl_pkg::OP_VEC) begin
        res.out_c0 = sat32(lerp(fa[0], ta[0], amt));
        res.out_c1 = sat32(lerp(fa[1], ta[1], amt));
        res.out_c2 = sat32(lerp(fa[2], ta[2], amt));
        return res;
      end
      // shortest path: flip end quaternion on a negative dot product only
      dot = '0;
      for (int i = 0; i < 4; i++) dot += 128'(fa[i]) * 128'(ta[i]);
      ssq = '0;
      for (int i = 0; i < 4; i++) begin
        r[i] = lerp(fa[i], (dot < 0) ? -ta[i] : ta[i], amt);
        m = (r[i] < 0) ? -r[i] : r[i];
        ssq += 66'(m) * 66'(m);
      end
      if (ssq == '0) begin
        res.zero_length = 1'b1;
        return res;
      end
      // a sum past 64 bits is treated as length 2^32
      len = (ssq[65:64] != 0) ? 64'd1 << 32 : root_floor(ssq[63:0]);
      res.out_c0 = sat32((r[0] * 65536) / longint'(len));
      res.out_c1 = sat32((r[1] * 65536) / longint'(len));
      res.out_c2 = sat32((r[2] * 65536) / longint'(len));
      res.out_c3 = sat32((r[3] * 65536) / longint'(len));
      return res;
    endfunction

    function void note_input(qnl_pkg::in_item_t it);
      pending.push_back(blend_result(it));
    endfunction

    function void check_result(qnl_pkg::out_item_t got);
      qnl_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.out_c0 !== exp.out_c0 || got.out_c1 !== exp.out_c1 ||
          got.out_c2 !== exp.out_c2 || got.out_c3 !== exp.out_c3 ||
          got.zero_length !== exp.zero_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp c=%0d,%0d,%0d,%0d z=%b  got c=%0d,%0d,%0d,%0d z=%b",
                   exp.out_c0, exp.out_c1, exp.out_c2, exp.out_c3, exp.zero_length,
                   got.out_c0, got.out_c1, got.out_c2, got.out_c3, got.zero_length);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   in_idle_pct;
  int   out_idle_pct;
  blend_scoreboard sb;

  qnl_in_if  in_ch();
  qnl_out_if out_ch();

  quaternion_nlerp_interpolator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // 2-unit period clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random backpressure, result check on each accepted item
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  // Offers one item; the sender may idle first. valid stays high across
  // back-to-back items, so it gets only one NBA per edge.
  task automatic push_item(input qnl_pkg::in_item_t it);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  // mix of full-range, extremes and values near unit scale
  function automatic qnl_pkg::word_t pick_word();
    case ($urandom_range(9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return qnl_pkg::word_t'($urandom_range(2)) - 1;
      3, 4: return qnl_pkg::word_t'($urandom);
      default: return qnl_pkg::word_t'($urandom_range(131072)) - 32'sd65536;
    endcase
  endfunction

  function automatic qnl_pkg::in_item_t random_item();
    qnl_pkg::in_item_t it;
    it.operation = $urandom_range(1) ? qnl_pkg::OP_QUAT : qnl_pkg::OP_VEC;
    it.from_c0 = pick_word();
    it.from_c1 = pick_word();
    it.from_c2 = pick_word();
    it.from_c3 = pick_word();
    it.to_c0 = pick_word();
    it.to_c1 = pick_word();
    it.to_c2 = pick_word();
    it.to_c3 = pick_word();
    case ($urandom_range(9))
      0: it.blend = qnl_pkg::word_t'($urandom);            // often clamped
      1: it.blend = qnl_pkg::word_t'($urandom_range(65536)) + 32'sd65537;
      2: it.blend = -qnl_pkg::word_t'($urandom_range(65536)) - 1;
      default: it.blend = qnl_pkg::word_t'($urandom_range(65536));
    endcase
    return it;
  endfunction

  function automatic qnl_pkg::in_item_t make_item(qnl_pkg::op_t op,
      qnl_pkg::word_t f0, qnl_pkg::word_t f1, qnl_pkg::word_t f2, qnl_pkg::word_t f3,
      qnl_pkg::word_t t0, qnl_pkg::word_t t1, qnl_pkg::word_t t2, qnl_pkg::word_t t3,
      qnl_pkg::word_t bl);
    qnl_pkg::in_item_t it;
    it = '{op, f0, f1, f2, f3, t0, t1, t2, t3, bl};
    return it;
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    localparam qnl_pkg::word_t MINW = 32'sh80000000;
    localparam qnl_pkg::word_t MAXW = 32'sh7fffffff;
    localparam qnl_pkg::word_t ONE = 32'sd65536;
    qnl_pkg::in_item_t it;
    sb = new();
    in_idle_pct = 23;
    out_idle_pct = 63;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: blend clamps and extremes in vector mode
    push_item(make_item(qnl_pkg::OP_VEC, MINW, MAXW, 0, 5, MAXW, MINW, ONE, 7, ONE));
    push_item(make_item(qnl_pkg::OP_VEC, MINW, MAXW, 0, 5, MAXW, MINW, ONE, 7, MAXW));
    push_item(make_item(qnl_pkg::OP_VEC, MINW, MAXW, 3, 5, MAXW, MINW, ONE, 7, MINW));
    push_item(make_item(qnl_pkg::OP_VEC, MINW, MAXW, -3, 0, MAXW, MINW, 4, 0, 32'sd32768));
    push_item(make_item(qnl_pkg::OP_VEC, 0, 1, -1, 0, -7, 7, 3, 0, 32'sd1));
    push_item(make_item(qnl_pkg::OP_VEC, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    // quaternion: identity blend, opposite sign (shortest path flip)
    push_item(make_item(qnl_pkg::OP_QUAT, 0, 0, 0, ONE, 0, ONE, 0, 0, 32'sd32768));
    push_item(make_item(qnl_pkg::OP_QUAT, 0, 0, 0, ONE, 0, 0, 0, -ONE, 32'sd32768));
    push_item(make_item(qnl_pkg::OP_QUAT, ONE, 0, 0, 0, -ONE, 0, 0, 0, 32'sd16384));
    // dot product exactly zero: no flip
    push_item(make_item(qnl_pkg::OP_QUAT, ONE, 0, 0, 0, 0, ONE, 0, 0, 32'sd40000));
    // zero length
    push_item(make_item(qnl_pkg::OP_QUAT, 0, 0, 0, 0, 0, 0, 0, 0, 32'sd1000));
    push_item(make_item(qnl_pkg::OP_QUAT, 0, 0, 0, 0, ONE, ONE, ONE, ONE, -5));
    // huge components: sums of squares near and past 64 bits
    push_item(make_item(qnl_pkg::OP_QUAT, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW,
                        ONE));
    push_item(make_item(qnl_pkg::OP_QUAT, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, 0));
    push_item(make_item(qnl_pkg::OP_QUAT, MAXW, MINW, MAXW, MINW, MINW, MAXW, MINW, MAXW,
                        MAXW));
    // tiny length and a lone extreme component: results within unit magnitude
    push_item(make_item(qnl_pkg::OP_QUAT, 1, 0, 0, 0, 1, 0, 0, 0, 32'sd100));
    push_item(make_item(qnl_pkg::OP_QUAT, -1, 1, -1, 1, 1, -1, 1, -1, 32'sd65535));
    push_item(make_item(qnl_pkg::OP_QUAT, MINW, 0, 0, 0, MAXW, 0, 0, 0, 32'sd32768));

    // hold off until everything is out
    in_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // random: three idling phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        in_idle_pct = 63;
        out_idle_pct = 23;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      it = random_item();
      push_item(it);
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
